// ===== rtl/u2c_pkg.sv =====
// Shared constants, types and lookup functions for the UTF-8 to code point decoder.
`default_nettype none

package u2c_pkg;

	// Widths of the word fields.
	localparam int BYTE_W  = 8;
	localparam int CP_W    = 32;
	localparam int UNIT_W  = 16;
	localparam int CNT_W   = 13;
	localparam int TAIL_W  = 3;
	localparam int OUT_W   = CP_W + UNIT_W + CNT_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// Characters counted per buffer before the count saturates.
	localparam int MAX_CHARS = 4096;

	// Replacement character for a stray continuation byte.
	localparam logic [CP_W-1:0] REPL_CHAR = 32'h0000_FFFD;

	// Top two bits that mark a continuation byte.
	localparam logic [1:0] CONT_TAG = 2'b10;

	typedef logic [TAIL_W-1:0] tail_t;
	typedef logic [CP_W-1:0]   cp_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Number of tail bytes that follow a given lead byte.
	function automatic tail_t tail_for_lead(input logic [BYTE_W-1:0] b);
		tail_t n;
		if (b < 8'hC0)
			n = 3'd0;
		else if (b < 8'hE0)
			n = 3'd1;
		else if (b < 8'hF0)
			n = 3'd2;
		else if (b < 8'hF8)
			n = 3'd3;
		else if (b < 8'hFC)
			n = 3'd4;
		else
			n = 3'd5;
		return n;
	endfunction

	// Offset that the summed lead and tail tag bits leave in the accumulator.
	function automatic cp_t seq_offset(input tail_t n);
		cp_t off;
		case (n)
			3'd1:    off = 32'h0000_3080;
			3'd2:    off = 32'h000E_2080;
			3'd3:    off = 32'h03C8_2080;
			3'd4:    off = 32'hFA08_2080;
			3'd5:    off = 32'h8208_2080;
			default: off = 32'h0000_0000;
		endcase
		return off;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/utf8_to_codepoint_decoder.sv =====
// Top level of the UTF-8 to code point decoder: byte stream in, one word per character out.
//
//   Channel   Direction  Word contents (lowest bit first)               Marker / flag
//   s_axis    in         data_byte[7:0]                                 tlast = buffer_end
//   m_axis    out        code_point[31:0], utf16_unit[47:32],           tlast = end_of_buffer
//                        char_count[60:48], zero fill [63:61]           tuser = replaced
//
// One byte word is accepted per cycle unless a finished character waits on a full, stalled
// output register. A byte is held in the input register, where the sequence state is
// updated, and a finished character passes from there into the output register.
// The sustained rate of one byte per cycle is set by the single input register
// feeding the shift-add-subtract path into the output register.
// Reset (arst_n low) clears the sequence state, the character count and both valid flags.
// A stalled output holds its word; the input register keeps moving as long as the
// byte in it yields no character or the output register is free or being emptied,
// so bytes that only extend a sequence pass even under a stall.
`default_nettype none

module utf8_to_codepoint_decoder
	import u2c_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [BYTE_W-1:0]      s_axis_tdata,   // data_byte[7:0]
	input  wire logic                   s_axis_tlast,   // buffer_end

	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // code_point, utf16_unit, char_count, zeros
	output logic                        m_axis_tuser,   // replaced
	output logic                        m_axis_tlast    // end_of_buffer
);

	// Input register stage.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// Sequence state.
	tail_t tail_left_q;
	tail_t tail_total_q;
	cp_t   acc_q;
	cnt_t  count_q;

	// Output register.
	logic  out_valid_q;
	cp_t   out_cp_q;
	cnt_t  out_count_q;
	logic  out_repl_q;
	logic  out_last_q;

	// Decode of the byte in the input register.
	logic  produce;
	logic  repl;
	cp_t   cp_next;
	cp_t   acc_next;
	tail_t tail_left_next;
	tail_t tail_total_next;
	tail_t lead_tails;
	tail_t tail_dec;
	cp_t   acc_shift_add;
	cnt_t  count_inc;
	logic  s1_moves;
	logic  in_accept;

	assign lead_tails    = tail_for_lead(byte_s1);
	assign tail_dec      = tail_left_q - 3'd1;
	assign acc_shift_add = {acc_q[CP_W-7:0], 6'b0} + {{(CP_W-BYTE_W){1'b0}}, byte_s1};

	always_comb begin
		produce         = 1'b0;
		repl            = 1'b0;
		cp_next         = acc_shift_add - seq_offset(tail_total_q);
		acc_next        = acc_q;
		tail_left_next  = tail_left_q;
		tail_total_next = tail_total_q;
		if (tail_left_q == 3'd0) begin
			if (byte_s1[7:6] == CONT_TAG) begin
				// A continuation byte where a lead byte belongs becomes U+FFFD.
				produce = 1'b1;
				repl    = 1'b1;
				cp_next = REPL_CHAR;
			end else begin
				acc_next = {{(CP_W-BYTE_W){1'b0}}, byte_s1};
				cp_next  = {{(CP_W-BYTE_W){1'b0}}, byte_s1};
				if (lead_tails == 3'd0) begin
					produce = 1'b1;
				end else begin
					tail_left_next  = lead_tails;
					tail_total_next = lead_tails;
				end
			end
		end else begin
			// Tail bytes are absorbed whatever their value.
			acc_next       = acc_shift_add;
			tail_left_next = tail_dec;
			produce        = (tail_dec == 3'd0);
		end
	end

	assign count_inc = (count_q < CNT_W'(MAX_CHARS)) ? count_q + cnt_t'(1) : CNT_W'(MAX_CHARS);

	// The input stage moves unless it holds a character that the full output cannot take.
	assign s1_moves      = !valid_s1 || !produce || !out_valid_q || m_axis_tready;
	assign s_axis_tready = s1_moves;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_moves) begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Sequence state; the end of a buffer returns everything to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_left_q  <= '0;
			tail_total_q <= '0;
			acc_q        <= '0;
			count_q      <= '0;
		end else if (valid_s1 && s1_moves) begin
			if (last_s1) begin
				tail_left_q  <= '0;
				tail_total_q <= '0;
				acc_q        <= '0;
				count_q      <= '0;
			end else begin
				tail_left_q  <= tail_left_next;
				tail_total_q <= tail_total_next;
				acc_q        <= acc_next;
				if (produce) begin
					count_q <= count_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && produce && s1_moves) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && produce && s1_moves) begin
			out_cp_q    <= cp_next;
			out_count_q <= count_inc;
			out_repl_q  <= repl;
			out_last_q  <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, out_count_q, out_cp_q[UNIT_W-1:0], out_cp_q};
	assign m_axis_tuser  = out_repl_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/u2c_checker.sv =====
// Port-level checks for the UTF-8 to code point decoder, bound to its top level.
`default_nettype none

module u2c_checker
	import u2c_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic                   m_axis_tuser,
	input wire logic                   m_axis_tlast
);

	// A stalled output word must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output word changed under stall");

	// A replaced character always carries U+FFFD.
	a_repl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[CP_W-1:0] == REPL_CHAR)
		else $error("replaced flag without U+FFFD");

	// The UTF-16 unit is the low half of the code point.
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[CP_W+UNIT_W-1:CP_W] == m_axis_tdata[UNIT_W-1:0])
		else $error("utf16 unit differs from code point");

	// Every character counts itself, so the count is never zero.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_W-1:CP_W+UNIT_W] != '0)
		else $error("character count is zero");

endmodule

bind utf8_to_codepoint_decoder u2c_checker u_u2c_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the UTF-8 to code point decoder stream block.
`timescale 1ns / 1ps

module tb_top;
	import u2c_pkg::*;

	// One byte word on the input stream: the raw byte and the buffer end marker.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} byte_word_t;

	// One character word as it should leave the block.
	typedef struct packed {
		cp_t               code_point;
		logic [UNIT_W-1:0] utf16_unit;
		logic              replaced;
		logic              end_of_buffer;
		cnt_t              char_count;
	} char_word_t;

	// Largest tail byte count, the last row of the lead byte ranges below.
	localparam int LONGEST_TAIL = 5;

	// Value the summed tag bits of a sequence leave behind, indexed by its tail count.
	localparam cp_t TAG_RESIDUE [0:LONGEST_TAIL] = '{
		32'h0000_0000, 32'h0000_3080, 32'h000E_2080,
		32'h03C8_2080, 32'hFA08_2080, 32'h8208_2080
	};

	// Lead byte ranges for 0 to 5 tail bytes, and the range of a proper tail byte.
	localparam logic [BYTE_W-1:0] LEAD_LO [0:LONGEST_TAIL] =
		'{8'h00, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC};
	localparam logic [BYTE_W-1:0] LEAD_HI [0:LONGEST_TAIL] =
		'{8'h7F, 8'hDF, 8'hEF, 8'hF7, 8'hFB, 8'hFF};
	localparam logic [BYTE_W-1:0] TAIL_LO = 8'h80;
	localparam logic [BYTE_W-1:0] TAIL_HI = 8'hBF;

	// Random bytes queued per idling phase, and the mismatches shown in full.
	localparam int PHASE_BYTES  = 325;
	localparam int SHOWN_ERRORS = 10;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [BYTE_W-1:0]      s_axis_tdata;   // data_byte[7:0]
	logic                   s_axis_tlast;   // buffer_end
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // code_point, utf16_unit, char_count, zeros
	logic                   m_axis_tuser;   // replaced
	logic                   m_axis_tlast;   // end_of_buffer

	// Bytes waiting to be driven, and characters waiting to come out of the block.
	byte_word_t byte_q[$];
	char_word_t char_q[$];

	// Idling rates of the current phase, in percent of cycles.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	// Set at a rising edge when the input word was taken at that edge.
	logic byte_taken;

	int unsigned mismatch_count;
	int unsigned queued_bytes;

	// Private copy of the decoder state, advanced once per accepted byte.
	tail_t tails_due;
	tail_t seq_tails;
	cp_t   acc;
	cnt_t  buf_chars;

	utf8_to_codepoint_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Records one finished character. The per-buffer count stops at MAX_CHARS, and
	// every character after that carries the saturated value.
	function automatic void push_char(cp_t cp, logic repl, logic last);
		char_word_t w;
		if (buf_chars < cnt_t'(MAX_CHARS))
			buf_chars = buf_chars + 1'b1;
		w.code_point    = cp;
		w.utf16_unit    = cp[UNIT_W-1:0];
		w.replaced      = repl;
		w.end_of_buffer = last;
		w.char_count    = buf_chars;
		char_q.push_back(w);
	endfunction

	// Advances the decoder state by one byte and records the character it completes.
	function automatic void decode_byte(logic [BYTE_W-1:0] b, logic last);
		tail_t n;
		if (tails_due == '0) begin
			if (b[7:6] == CONT_TAG) begin
				// A continuation byte where a lead byte belongs stands for U+FFFD.
				push_char(REPL_CHAR, 1'b1, last);
			end else begin
				casez (b)
					8'b0???_????: n = 3'd0;
					8'b110?_????: n = 3'd1;
					8'b1110_????: n = 3'd2;
					8'b1111_0???: n = 3'd3;
					8'b1111_10??: n = 3'd4;
					default:      n = 3'd5;
				endcase
				acc = cp_t'(b);
				if (n == '0) begin
					push_char(acc, 1'b0, last);
				end else begin
					tails_due = n;
					seq_tails = n;
				end
			end
		end else begin
			// Tail bytes are folded in whatever their value; the tag bits of the
			// whole sequence are taken out in one subtraction at the end.
			acc = (acc << 6) + cp_t'(b);
			tails_due = tails_due - 1'b1;
			if (tails_due == '0)
				push_char(acc - TAG_RESIDUE[seq_tails], 1'b0, last);
		end
		// The end of a buffer drops any unfinished sequence and restarts the count.
		if (last) begin
			tails_due = '0;
			seq_tails = '0;
			acc       = '0;
			buf_chars = '0;
		end
	endfunction

	// Driver: a new word is presented only at a falling edge after the previous
	// one was taken, so valid never drops while a word is waiting.
	always @(negedge clk) begin : drive_bytes
		byte_word_t nxt;
		logic       nvalid;
		logic [BYTE_W-1:0] ndata;
		logic       nlast;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			m_axis_tready <= 1'b0;
		end else begin
			nvalid = s_axis_tvalid;
			ndata  = s_axis_tdata;
			nlast  = s_axis_tlast;
			if (!s_axis_tvalid || byte_taken) begin
				nvalid = 1'b0;
				if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt    = byte_q.pop_front();
					nvalid = 1'b1;
					ndata  = nxt.data;
					nlast  = nxt.last;
				end
			end
			s_axis_tvalid <= nvalid;
			s_axis_tdata  <= ndata;
			s_axis_tlast  <= nlast;
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: every byte taken feeds the private decoder, and every character
	// taken is compared with the oldest one still owed.
	always @(posedge clk or negedge arst_n) begin : watch_streams
		char_word_t got;
		char_word_t want;
		if (!arst_n) begin
			byte_taken <= 1'b0;
		end else begin
			byte_taken <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready)
				decode_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got.code_point    = m_axis_tdata[CP_W-1:0];
				got.utf16_unit    = m_axis_tdata[CP_W +: UNIT_W];
				got.char_count    = m_axis_tdata[CP_W+UNIT_W +: CNT_W];
				got.replaced      = m_axis_tuser;
				got.end_of_buffer = m_axis_tlast;
				if (char_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= SHOWN_ERRORS)
						$display("%0t: unexpected word cp=%h unit=%h repl=%b eob=%b cnt=%0d",
							$realtime, got.code_point, got.utf16_unit, got.replaced,
							got.end_of_buffer, got.char_count);
				end else begin
					want = char_q.pop_front();
					if (got != want) begin
						mismatch_count++;
						if (mismatch_count <= SHOWN_ERRORS) begin
							$display("%0t: mismatch, expected cp=%h unit=%h repl=%b eob=%b cnt=%0d",
								$realtime, want.code_point, want.utf16_unit,
								want.replaced, want.end_of_buffer, want.char_count);
							$display("%0t: mismatch, actual   cp=%h unit=%h repl=%b eob=%b cnt=%0d",
								$realtime, got.code_point, got.utf16_unit,
								got.replaced, got.end_of_buffer, got.char_count);
						end
					end
				end
			end
		end
	end

	task automatic queue_byte(logic [BYTE_W-1:0] b, logic last);
		byte_word_t w;
		w.data = b;
		w.last = last;
		byte_q.push_back(w);
		queued_bytes++;
	endtask

	// Builds one buffer of random characters. Most are well-formed sequences of
	// every length; some are random noise bytes or stray continuation bytes, some
	// carry a malformed tail, and now and then the buffer ends inside a sequence.
	task automatic queue_buffer();
		logic [BYTE_W-1:0] bytes[$];
		int unsigned chars;
		int unsigned kind;
		int unsigned ntail;
		int unsigned keep;
		chars = $urandom_range(24, 1);
		for (int c = 0; c < chars; c++) begin
			kind = $urandom_range(99);
			if (kind < 8) begin
				bytes.push_back(8'($urandom_range(255)));
			end else if (kind < 14) begin
				bytes.push_back(8'($urandom_range(TAIL_HI, TAIL_LO)));
			end else begin
				kind = $urandom_range(99);
				if (kind < 30)
					ntail = 0;
				else if (kind < 52)
					ntail = 1;
				else if (kind < 72)
					ntail = 2;
				else if (kind < 88)
					ntail = 3;
				else
					ntail = $urandom_range(LONGEST_TAIL, 4);
				keep = ntail;
				// Cut the last character of the buffer short now and then.
				if (c == chars - 1 && ntail != 0 && $urandom_range(99) < 15)
					keep = $urandom_range(ntail - 1);
				bytes.push_back(8'($urandom_range(LEAD_HI[ntail], LEAD_LO[ntail])));
				for (int t = 0; t < keep; t++) begin
					if ($urandom_range(99) < 5)
						bytes.push_back(8'($urandom_range(255)));
					else
						bytes.push_back(8'($urandom_range(TAIL_HI, TAIL_LO)));
				end
			end
		end
		foreach (bytes[i])
			queue_byte(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic run_phase(int unsigned send_pct, int unsigned recv_pct);
		int unsigned stop_at;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		stop_at = queued_bytes + PHASE_BYTES;
		while (queued_bytes < stop_at)
			queue_buffer();
		while (byte_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tlast   = 1'b0;
		m_axis_tready  = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		mismatch_count = 0;
		queued_bytes   = 0;
		tails_due      = '0;
		seq_tails      = '0;
		acc            = '0;
		buf_chars      = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words: the ASCII extremes, stray continuation bytes (one of them
		// ending a buffer), one sequence of each length at the low or high end of its
		// range, a malformed tail, and a buffer that ends in the middle of a sequence.
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hBF, 1'b1);
		queue_byte(8'hC0, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hEF, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hF0, 1'b0);
		queue_byte(8'h90, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hFB, 1'b0);
		repeat (4) queue_byte(8'hBF, 1'b0);
		queue_byte(8'hFC, 1'b0);
		repeat (5) queue_byte(8'h80, 1'b0);
		queue_byte(8'hC2, 1'b0);
		queue_byte(8'h41, 1'b1);
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h82, 1'b1);

		// Random traffic under each idling pattern in turn.
		run_phase(0, 0);
		run_phase(45, 0);
		run_phase(0, 45);
		run_phase(32, 32);

		// Let the last word go, then wait for every owed character plus a margin
		// in which any stray extra word would show up.
		while (s_axis_tvalid)
			@(posedge clk);
		while (char_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_count == 0 && char_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
